/* hw/rtl/t2m_pkg.sv */
// Shared types, symbol codes and the Morse letter table for the text to Morse sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package t2m_pkg;

    // Output symbol codes.
    localparam logic [2:0] SYM_DOT        = 3'd0;
    localparam logic [2:0] SYM_DASH       = 3'd1;
    localparam logic [2:0] SYM_LETTER_GAP = 3'd2;
    localparam logic [2:0] SYM_WORD_GAP   = 3'd3;
    localparam logic [2:0] SYM_END        = 3'd4;

    // Word position codes.
    localparam logic [1:0] WP_NONE    = 2'd0;
    localparam logic [1:0] WP_LETTER  = 2'd1;
    localparam logic [1:0] WP_PENDING = 2'd2;

    // Gap that precedes a letter.
    localparam logic [1:0] GAP_NONE   = 2'd0;
    localparam logic [1:0] GAP_LETTER = 2'd1;
    localparam logic [1:0] GAP_WORD   = 2'd2;

    localparam int MAX_ELEMS = 4;

    // One job handed from the front end to the back end.
    typedef struct packed {
        logic [1:0] gap;
        logic [2:0] len;
        logic [3:0] elems;  // first element in bit 3, 1 is a dash
        logic       eom;
    } t_job;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GAP,
        PH_ELEM,
        PH_END
    } t_phase;

    // International Morse table: bits 6..4 element count, bits 3..0 elements.
    function automatic logic [6:0] letter_pattern(input logic [4:0] idx);
        logic [6:0] pat;
        case (idx)
            5'd0:    pat = 7'h24;
            5'd1:    pat = 7'h48;
            5'd2:    pat = 7'h4A;
            5'd3:    pat = 7'h38;
            5'd4:    pat = 7'h10;
            5'd5:    pat = 7'h42;
            5'd6:    pat = 7'h3C;
            5'd7:    pat = 7'h40;
            5'd8:    pat = 7'h20;
            5'd9:    pat = 7'h47;
            5'd10:   pat = 7'h3A;
            5'd11:   pat = 7'h44;
            5'd12:   pat = 7'h2C;
            5'd13:   pat = 7'h28;
            5'd14:   pat = 7'h3E;
            5'd15:   pat = 7'h46;
            5'd16:   pat = 7'h4D;
            5'd17:   pat = 7'h34;
            5'd18:   pat = 7'h30;
            5'd19:   pat = 7'h18;
            5'd20:   pat = 7'h32;
            5'd21:   pat = 7'h41;
            5'd22:   pat = 7'h36;
            5'd23:   pat = 7'h49;
            5'd24:   pat = 7'h4B;
            5'd25:   pat = 7'h4C;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

/* hw/rtl/t2m_front.sv */
// Front end: accepts text bytes, classifies them and tracks the word position.
// Emits one job per letter or end of message. Depends on t2m_pkg.
`timescale 1ns / 1ps

module t2m_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [7:0]   i_char,
    input  logic         i_eom,
    output logic         o_ready,
    input  logic         i_queue_ready,
    output logic         o_push,
    output t2m_pkg::t_job o_job
);
    import t2m_pkg::*;

    logic [1:0] r_wpos;
    logic [1:0] n_wpos;
    logic       accept;
    logic       is_letter;
    logic       is_space;
    logic [4:0] idx;
    logic [6:0] pat;

    assign o_ready = i_queue_ready;
    assign accept  = i_valid && i_queue_ready;

    always_comb begin
        is_letter = 1'b0;
        is_space  = 1'b0;
        idx       = 5'd0;
        if (i_char inside {[8'h41:8'h5A]}) begin
            is_letter = 1'b1;
            idx       = 5'(i_char - 8'h41);
        end else if (i_char inside {[8'h61:8'h7A]}) begin
            is_letter = 1'b1;
            idx       = 5'(i_char - 8'h61);
        end else if (i_char inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
            is_space = 1'b1;
        end
    end

    assign pat = letter_pattern(idx);

    always_comb begin
        o_job.elems = pat[3:0];
        o_job.eom   = i_eom;
        o_job.len   = (pat[6:4] > 3'(MAX_ELEMS)) ? 3'(MAX_ELEMS) : pat[6:4];
        if (!is_letter) begin
            o_job.len = 3'd0;
        end
        case (r_wpos)
            WP_LETTER:  o_job.gap = is_letter ? GAP_LETTER : GAP_NONE;
            WP_PENDING: o_job.gap = is_letter ? GAP_WORD : GAP_NONE;
            default:    o_job.gap = GAP_NONE;
        endcase
    end

    assign o_push = accept && (is_letter || i_eom);

    always_comb begin
        n_wpos = r_wpos;
        if (accept) begin
            if (i_eom) begin
                n_wpos = WP_NONE;
            end else if (is_letter) begin
                n_wpos = WP_LETTER;
            end else if (is_space && r_wpos == WP_LETTER) begin
                n_wpos = WP_PENDING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= WP_NONE;
        end else begin
            r_wpos <= n_wpos;
        end
    end

endmodule

/* hw/rtl/t2m_queue.sv */
// Short job queue between the front and back ends.
// Register array with read and write pointers. Depends on t2m_pkg.
`timescale 1ns / 1ps

module t2m_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t2m_pkg::t_job i_job,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output t2m_pkg::t_job o_job
);
    import t2m_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/t2m_back.sv */
// Back end: plays one job out as Morse symbols into an output register, one symbol per
// cycle while the output is not stalled. Depends on t2m_pkg.
`timescale 1ns / 1ps

module t2m_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  t2m_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_data,
    output logic          o_last
);
    import t2m_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    t_job       r_job;
    t_job       n_job;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;

    logic       can_load;
    logic       advance;
    logic       done;
    logic       elem_last;
    logic [2:0] sym;
    logic [1:0] on_units;
    logic [2:0] off_units;
    logic       sym_last;

    function automatic t_phase first_phase(input t_job job);
        t_phase ph;
        if (job.gap != GAP_NONE) begin
            ph = PH_GAP;
        end else if (job.len != 3'd0) begin
            ph = PH_ELEM;
        end else if (job.eom) begin
            ph = PH_END;
        end else begin
            ph = PH_IDLE;
        end
        return ph;
    endfunction

    assign can_load  = !r_out_valid || i_ready;
    assign advance   = (r_phase != PH_IDLE) && can_load;
    assign elem_last = ({1'b0, r_idx} + 3'd1) >= r_job.len;

    // Symbol output for the current phase.
    always_comb begin
        sym       = SYM_END;
        on_units  = 2'd0;
        off_units = 3'd0;
        sym_last  = 1'b0;
        done      = 1'b0;
        case (r_phase)
            PH_GAP: begin
                if (r_job.gap == GAP_LETTER) begin
                    sym       = SYM_LETTER_GAP;
                    off_units = 3'd3;
                end else begin
                    sym       = SYM_WORD_GAP;
                    off_units = 3'd7;
                end
                done     = (r_job.len == 3'd0) && !r_job.eom;
                sym_last = done;
            end
            PH_ELEM: begin
                if (r_job.elems[2'd3 - r_idx]) begin
                    sym      = SYM_DASH;
                    on_units = 2'd3;
                end else begin
                    sym      = SYM_DOT;
                    on_units = 2'd1;
                end
                off_units = 3'd1;
                done      = elem_last && !r_job.eom;
                sym_last  = done;
            end
            PH_END: begin
                done     = 1'b1;
                sym_last = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    // Next phase, element index and job fetch.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_job   = r_job;
        o_pop   = 1'b0;
        if (r_phase == PH_IDLE || (advance && done)) begin
            if (i_job_valid) begin
                o_pop   = 1'b1;
                n_job   = i_job;
                n_idx   = 2'd0;
                n_phase = first_phase(i_job);
            end else begin
                n_phase = PH_IDLE;
            end
        end else if (advance) begin
            case (r_phase)
                PH_GAP: begin
                    n_idx   = 2'd0;
                    n_phase = (r_job.len != 3'd0) ? PH_ELEM : PH_END;
                end
                PH_ELEM: begin
                    if (elem_last) begin
                        n_phase = PH_END;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        if (advance) begin
            r_out_data <= {off_units, on_units, sym};
            r_out_last <= sym_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

/* hw/rtl/text_to_morse_sequencer.sv */
// Top level of the text to Morse sequencer: front end, job queue and symbol back end.
// Depends on t2m_pkg, t2m_front, t2m_queue and t2m_back.
//
//  Channel  | Direction | tdata (low bit up)                          | tlast
//  s_axis   | in        | char_byte[7:0]                              | end_of_message
//  m_axis   | out       | symbol[2:0], on_units[4:3], off_units[7:5]  | last
//
// A byte is taken whenever the job queue has room; bytes that give no symbols
// never enter the queue. The back end sends one symbol per cycle unless the output is
// stalled. A letter of n elements gives n to n+2 symbols; symbol output bounds throughput.
// The output register lets the back end fill it again in the cycle it is taken.
// Reset is synchronous; it empties the queue and starts a new message.
`timescale 1ns / 1ps

module text_to_morse_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // char_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // symbol[2:0], on_units[4:3], off_units[7:5]
    output logic       m_axis_tlast
);
    import t2m_pkg::*;

    logic push;
    logic pop;
    logic q_ready;
    logic q_valid;
    t_job front_job;
    t_job q_job;

    t2m_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_char        (s_axis_tdata),
        .i_eom         (s_axis_tlast),
        .o_ready       (s_axis_tready),
        .i_queue_ready (q_ready),
        .o_push        (push),
        .o_job         (front_job)
    );

    t2m_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    t2m_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

/* hw/rtl/t2m_checker.sv */
// Port-level checks for the text to Morse sequencer, bound to the top level.
// Depends on t2m_pkg.
`timescale 1ns / 1ps

module t2m_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    import t2m_pkg::*;

    // A stalled output transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Each symbol carries its fixed lit and dark durations.
    a_symbol_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata == {3'd1, 2'd1, SYM_DOT}) ||
            (m_axis_tdata == {3'd1, 2'd3, SYM_DASH}) ||
            (m_axis_tdata == {3'd3, 2'd0, SYM_LETTER_GAP}) ||
            (m_axis_tdata == {3'd7, 2'd0, SYM_WORD_GAP}) ||
            (m_axis_tdata == {3'd0, 2'd0, SYM_END}))
        else $error("symbol with wrong durations");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == SYM_END |-> m_axis_tlast)
        else $error("end marker not marked last");

endmodule

bind text_to_morse_sequencer t2m_checker u_t2m_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/tb.sv */
// Self-checking testbench for text_to_morse_sequencer: streams text bytes in and checks
// every Morse symbol against an in-bench predictor. Depends on t2m_pkg and the RTL top.
`timescale 1ns / 1ps

module tb;
    import t2m_pkg::*;

    localparam int CYCLE_LIMIT   = 150000;
    localparam int RANDOM_ITEMS  = 330;
    localparam int DRAIN_CYCLES  = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 80;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Element count in bits 6..4, elements in bits 3..0 with the first in bit 3.
    localparam logic [6:0] MORSE_LETTERS [26] = '{
        7'h24, 7'h48, 7'h4A, 7'h38, 7'h10, 7'h42, 7'h3C, 7'h40, 7'h20, 7'h47, 7'h3A,
        7'h44, 7'h2C, 7'h28, 7'h3E, 7'h46, 7'h4D, 7'h34, 7'h30, 7'h18, 7'h32, 7'h41,
        7'h36, 7'h49, 7'h4B, 7'h4C
    };

    typedef struct packed {
        logic       eom;
        logic [7:0] ch;
    } t_text_item;

    // Same layout as {m_axis_tlast, m_axis_tdata}.
    typedef struct packed {
        logic       last;
        logic [2:0] off_units;
        logic [1:0] on_units;
        logic [2:0] sym;
    } t_morse_sym;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // char_byte[7:0]
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // symbol[2:0], on_units[4:3], off_units[7:5]
    logic       m_axis_tlast;

    t_text_item pending_text [$];
    t_morse_sym expected_symbols [$];
    logic [1:0] word_pos = WP_NONE;
    int         mismatches = 0;
    int         cycles = 0;

    text_to_morse_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_morse_sym make_sym(logic [2:0] sym, logic [1:0] on_u,
                                            logic [2:0] off_u);
        t_morse_sym s;
        s.last      = 1'b0;
        s.off_units = off_u;
        s.on_units  = on_u;
        s.sym       = sym;
        return s;
    endfunction

    // Predicts the symbols one accepted text byte produces and updates the word position.
    task automatic encode_text(input t_text_item item);
        t_morse_sym syms [$];
        logic [6:0] pat;
        int         count;
        int         idx;
        idx = -1;
        if (item.ch >= CH_UPPER_A && item.ch <= CH_UPPER_Z)
            idx = int'(item.ch - CH_UPPER_A);
        else if (item.ch >= CH_LOWER_A && item.ch <= CH_LOWER_Z)
            idx = int'(item.ch - CH_LOWER_A);

        if (idx >= 0) begin
            pat   = MORSE_LETTERS[idx];
            count = (pat[6:4] > 3'd4) ? 4 : int'(pat[6:4]);
            if (word_pos == WP_LETTER)
                syms.push_back(make_sym(SYM_LETTER_GAP, 2'd0, 3'd3));
            else if (word_pos == WP_PENDING)
                syms.push_back(make_sym(SYM_WORD_GAP, 2'd0, 3'd7));
            for (int i = 0; i < count; i++) begin
                if (pat[3 - i])
                    syms.push_back(make_sym(SYM_DASH, 2'd3, 3'd1));
                else
                    syms.push_back(make_sym(SYM_DOT, 2'd1, 3'd1));
            end
            word_pos = WP_LETTER;
        end else if (item.ch == CH_SPACE || item.ch == CH_TAB ||
                     item.ch == CH_LF || item.ch == CH_CR) begin
            if (word_pos == WP_LETTER)
                word_pos = WP_PENDING;
        end

        if (item.eom) begin
            syms.push_back(make_sym(SYM_END, 2'd0, 3'd0));
            word_pos = WP_NONE;
        end

        if (syms.size() > 0)
            syms[syms.size() - 1].last = 1'b1;
        foreach (syms[k])
            expected_symbols.push_back(syms[k]);
    endtask

    function automatic void add_text(logic [7:0] ch, logic eom);
        t_text_item item;
        item.ch  = ch;
        item.eom = eom;
        pending_text.push_back(item);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Sender: bursts of random length separated by random gaps, sometimes none.
    t_text_item on_bus;
    int         burst_left = 0;
    int         gap_left = 0;

    always @(posedge i_clk) begin
        logic take_next;
        logic next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                encode_text(on_bus);
            take_next  = !s_axis_tvalid || s_axis_tready;
            next_valid = s_axis_tvalid && !s_axis_tready;
            if (take_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                    next_valid = 1'b0;
                end else if (pending_text.size() > 0) begin
                    on_bus     = pending_text.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    next_valid = 1'b0;
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= on_bus.ch;
            s_axis_tlast  <= on_bus.eom;
        end
    end

    // Receiver: switches among stall styles and once holds off long enough to back up the queue.
    int symbols_seen = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int step = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_morse_sym got;
        t_morse_sym want;
        logic       next_ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata};
                symbols_seen++;
                if (expected_symbols.size() == 0) begin
                    $display({"%0t: unexpected transaction: expected none, ",
                              "actual sym=%0d on=%0d off=%0d last=%0b"},
                             $time, got.sym, got.on_units, got.off_units, got.last);
                    mismatches++;
                end else begin
                    want = expected_symbols.pop_front();
                    check_field("symbol", want.sym, got.sym);
                    check_field("on_units", want.on_units, got.on_units);
                    check_field("off_units", want.off_units, got.off_units);
                    check_field("last", want.last, got.last);
                end
            end

            step++;
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 250);
            end else begin
                mode_left--;
            end

            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!hold_done && symbols_seen >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES;
                next_ready = 1'b0;
            end else begin
                case (stall_mode)
                    0: next_ready = 1'b1;
                    1: next_ready = 1'($urandom_range(0, 1));
                    2: next_ready = (step % 5) != 0 && (step % 7) != 3;
                    default: next_ready = ($urandom_range(0, 5) == 0);
                endcase
            end
            m_axis_tready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int         added;
        int         pick;
        logic [7:0] ch;

        // Directed part: field extremes, both cases, whitespace kinds and message ends.
        add_text(8'h00, 1'b0);
        add_text(8'hFF, 1'b0);
        add_text(CH_SPACE, 1'b0);          // whitespace before any letter
        add_text(CH_UPPER_A, 1'b0);        // first letter, no gap
        add_text(CH_LOWER_Z, 1'b0);        // letter gap
        add_text(CH_SPACE, 1'b0);
        add_text(CH_TAB, 1'b0);            // whitespace run gives one word gap
        add_text("Q", 1'b0);
        add_text(CH_CR, 1'b0);
        add_text(CH_LF, 1'b0);
        add_text(CH_LOWER_A, 1'b0);
        add_text(8'h40, 1'b0);             // bytes just outside the letter ranges
        add_text(8'h5B, 1'b0);
        add_text(8'h60, 1'b0);
        add_text(8'h7B, 1'b0);
        add_text(CH_SPACE, 1'b0);
        add_text(CH_UPPER_Z, 1'b1);        // word gap, four elements and end marker
        add_text(CH_SPACE, 1'b1);          // end marker alone
        add_text("e", 1'b0);
        add_text(CH_SPACE, 1'b0);
        add_text("#", 1'b1);               // pending word gap is dropped
        add_text("M", 1'b0);
        add_text("t", 1'b1);

        added = 0;
        while (added < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                ch = CH_UPPER_A + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1) == 1)
                    ch = ch | CASE_BIT;
            end else if (pick < 86) begin
                case ($urandom_range(0, 3))
                    0: ch = CH_SPACE;
                    1: ch = CH_TAB;
                    2: ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
            add_text(ch, $urandom_range(0, 24) == 0);
            added++;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_text.size() != 0 || s_axis_tvalid || expected_symbols.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_symbols.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
